// File: design/ssr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
package ssr_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = 4;   // holds 0..MAX_RESULTS
	localparam int PTR_W       = 3;   // indexes one of MAX_RESULTS results
	localparam int IDX_W       = 5;   // window arithmetic, up to 16

	typedef enum logic [1:0] {
		REG_TARGET_BYTES  = 2'd0,
		REG_TARGET_LENGTH = 2'd1,
		REG_UPDATE_BYTES  = 2'd2,
		REG_UPDATE_LENGTH = 2'd3
	} cfg_reg_t;

	// Results caused by one request
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] data;
		logic [CNT_W-1:0]            count;
		logic                        stream_end;
		logic                        marker;
	} ssr_group_t;

endpackage

// File: design/ssr_step.sv
// Window update and result generation for one input byte.
module ssr_step #(
	parameter int MAX_PATTERN = 8
) (
	input  logic [MAX_PATTERN-1:0][7:0]         win,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]    fill,
	input  logic [63:0]                         target_bytes,
	input  logic [3:0]                          target_len,
	input  logic [63:0]                         update_bytes,
	input  logic [3:0]                          update_len,
	input  logic [7:0]                          in_byte,
	input  logic                                stream_end,
	output logic [MAX_PATTERN-1:0][7:0]         win_nxt,
	output logic [$clog2(MAX_PATTERN+1)-1:0]    fill_nxt,
	output ssr_pkg::ssr_group_t                 grp
);
	import ssr_pkg::*;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN-1:0][7:0] w_ins;
	logic [IDX_W-1:0]            fill_ins;
	logic [IDX_W-1:0]            tl;
	logic [IDX_W-1:0]            c1;
	logic [IDX_W-1:0]            drop;
	logic [IDX_W-1:0]            rem;
	logic [IDX_W-1:0]            total;
	logic [IDX_W-1:0]            src;
	logic                        full;
	logic                        match;

	always_comb begin
		tl = IDX_W'(target_len);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			w_ins[i] = (IDX_W'(i) == IDX_W'(fill)) ? in_byte : win[i];
		end
		fill_ins = (IDX_W'(fill) == IDX_W'(MAX_PATTERN)) ? IDX_W'(fill) : IDX_W'(fill) + 1'b1;
		full = fill_ins >= tl;

		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (IDX_W'(i) < tl && w_ins[i] != target_bytes[8*i +: 8]) begin
				match = 1'b0;
			end
		end

		if (!full) begin
			c1   = '0;
			drop = '0;
		end else if (match) begin
			c1   = IDX_W'(update_len);
			drop = tl;
		end else begin
			c1   = IDX_W'(1);
			drop = IDX_W'(1);
		end
		rem   = (drop >= fill_ins) ? '0 : fill_ins - drop;
		total = c1 + (stream_end ? rem : '0);

		// results: head part (replacement or oldest byte), then the flushed window
		for (int k = 0; k < MAX_RESULTS; k++) begin
			grp.data[k] = 8'h00;
			if (IDX_W'(k) < c1) begin
				grp.data[k] = match ? update_bytes[8*k +: 8] : w_ins[0];
			end else begin
				src = IDX_W'(k) - c1 + drop;
				for (int j = 0; j < MAX_PATTERN; j++) begin
					if (src == IDX_W'(j)) begin
						grp.data[k] = w_ins[j];
					end
				end
			end
		end
		src = '0;

		grp.stream_end = stream_end;
		grp.marker     = 1'b0;
		if (total > IDX_W'(MAX_RESULTS)) begin
			grp.count = CNT_W'(MAX_RESULTS);
		end else begin
			grp.count = total[CNT_W-1:0];
		end
		if (stream_end && total == '0) begin
			grp.count  = CNT_W'(1);
			grp.marker = 1'b1;
			grp.data   = '0;
		end

		for (int j = 0; j < MAX_PATTERN; j++) begin
			win_nxt[j] = 8'h00;
			for (int m = 0; m < MAX_PATTERN; m++) begin
				if (IDX_W'(m) == IDX_W'(j) + drop) begin
					win_nxt[j] = w_ins[m];
				end
			end
		end
		fill_nxt = stream_end ? '0 : rem[FILL_W-1:0];
	end

endmodule

// File: design/ssr_out.sv
// Result register: holds one group of results and sends them one per cycle while the receiver is ready.
module ssr_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ssr_pkg::ssr_group_t grp_in,
	output logic                free,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic                m_axis_tlast,
	output logic [1:0]          m_axis_tuser
);
	import ssr_pkg::*;

	ssr_group_t       grp_q;
	logic             valid_q;
	logic [PTR_W-1:0] ptr_q;
	logic             at_last;
	logic             take;

	assign at_last = {1'b0, ptr_q} == (grp_q.count - 1'b1);
	assign take    = valid_q && m_axis_tready;
	assign free    = !valid_q || (take && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				ptr_q   <= '0;
			end else if (take) begin
				if (at_last) begin
					valid_q <= 1'b0;
					ptr_q   <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_in;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = grp_q.data[ptr_q];
	assign m_axis_tlast  = at_last;
	assign m_axis_tuser  = {grp_q.stream_end && at_last, !grp_q.marker};

endmodule

// File: design/stream_string_replace.sv
// Top level of the streaming fixed-pattern find-and-replace block.
//
// Input stream: one byte per request on s_axis_tdata, s_axis_tlast marks the
// final byte of a stream and flushes the match window. Output stream: one
// byte per request on m_axis_tdata; m_axis_tlast closes the results caused by
// one input byte, m_axis_tuser[1] flags the last result of a stream and
// m_axis_tuser[0] is clear only on an end marker that carries no byte.
// Configuration (pattern, replacement, lengths) is written through
// cfg_we/cfg_addr/cfg_wdata; the user must write it only while the stream
// is idle; the block does not enforce this. A byte's results, if any, appear
// the cycle after it is accepted. Input: one byte per cycle while each byte
// causes at most one result and the receiver is ready; a byte with more
// results holds the input as the single result register drains one per cycle.
// Reset clears the window and loads the default pattern settings. When the
// receiver stalls, the held result stays put and the input stops once the
// result register cannot free up in that cycle.
module stream_string_replace #(
	parameter int MAX_PATTERN = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tlast,   // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic        m_axis_tlast,   // run_last
	output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] output_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);
	import ssr_pkg::*;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	logic [63:0]                 target_bytes_q;
	logic [3:0]                  target_length_q;
	logic [63:0]                 update_bytes_q;
	logic [3:0]                  update_length_q;
	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [FILL_W-1:0]           fill_q;

	logic [MAX_PATTERN-1:0][7:0] win_nxt;
	logic [FILL_W-1:0]           fill_nxt;
	logic [3:0]                  tl_eff;
	logic [3:0]                  ul_eff;
	logic                        accept;
	logic                        free;
	ssr_group_t                  grp;

	always_comb begin
		if (target_length_q == 4'd0) begin
			tl_eff = 4'd1;
		end else if (target_length_q > 4'(MAX_PATTERN)) begin
			tl_eff = 4'(MAX_PATTERN);
		end else begin
			tl_eff = target_length_q;
		end
		ul_eff = (update_length_q > 4'(MAX_RESULTS)) ? 4'(MAX_RESULTS) : update_length_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_bytes_q  <= '0;
			target_length_q <= 4'd1;
			update_bytes_q  <= '0;
			update_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_TARGET_BYTES:  target_bytes_q  <= cfg_wdata;
				REG_TARGET_LENGTH: target_length_q <= cfg_wdata[3:0];
				REG_UPDATE_BYTES:  update_bytes_q  <= cfg_wdata;
				REG_UPDATE_LENGTH: update_length_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			win_q  <= win_nxt;
			fill_q <= fill_nxt;
		end
	end

	assign s_axis_tready = free;
	assign accept        = s_axis_tvalid && free;

	ssr_step #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_step (
		.win         (win_q),
		.fill        (fill_q),
		.target_bytes(target_bytes_q),
		.target_len  (tl_eff),
		.update_bytes(update_bytes_q),
		.update_len  (ul_eff),
		.in_byte     (s_axis_tdata),
		.stream_end  (s_axis_tlast),
		.win_nxt     (win_nxt),
		.fill_nxt    (fill_nxt),
		.grp         (grp)
	);

	ssr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && grp.count != '0),
		.grp_in       (grp),
		.free         (free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// File: design/ssr_checker.sv
// Port-level assertions for the find-and-replace block, bound to the top level.
module ssr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [1:0]  m_axis_tuser
);

	// an end marker closes both the run and the stream
	a_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1])
		else $error("end marker without run and stream end");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
		else $error("end marker carries a byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("stream end not on the last result of a request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a final byte is always followed by a result in the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
		else $error("stream end produced no result");

endmodule

bind stream_string_replace ssr_checker u_ssr_checker (.*);
